@@ src/typed_sensor_value_decoder_macros.svh @@
// ---------------------------------------------------------------------------
// typed_sensor_value_decoder_macros.svh
// Assertion helpers used by the decoder queue RTL (tsvd_fifo).
// ---------------------------------------------------------------------------
`ifndef TYPED_SENSOR_VALUE_DECODER_MACROS_SVH
`define TYPED_SENSOR_VALUE_DECODER_MACROS_SVH

// same-cycle implication
`define TSVD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsvd assertion failed");

// next-cycle implication
`define TSVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsvd assertion failed");

`endif

@@ src/tsvd_pkg.sv @@
// ---------------------------------------------------------------------------
// tsvd_pkg
// Types, constants and helper functions of the typed sensor value decoder.
// ---------------------------------------------------------------------------
package tsvd_pkg;

   localparam int TSVD_QUEUE_DEPTH = 2;
   localparam int EXP_W = 13;

   localparam logic [3:0] PT_U8  = 4'd0;
   localparam logic [3:0] PT_S8  = 4'd1;
   localparam logic [3:0] PT_U16 = 4'd2;
   localparam logic [3:0] PT_S16 = 4'd3;
   localparam logic [3:0] PT_U24 = 4'd4;
   localparam logic [3:0] PT_U32 = 4'd5;
   localparam logic [3:0] PT_S32 = 4'd6;
   localparam logic [3:0] PT_F32 = 4'd7;

   localparam logic [1:0] CSR_POINT_TYPE    = 2'd0;
   localparam logic [1:0] CSR_BYTE_ORDER    = 2'd1;
   localparam logic [1:0] CSR_SCALE_FACTOR  = 2'd2;
   localparam logic [1:0] CSR_SCALE_ENABLED = 2'd3;

   localparam logic [63:0] SCALE_RESET = 64'h3FF0_0000_0000_0000;

   typedef struct packed {
      logic [3:0]  point_type;
      logic        byte_order;
      logic [63:0] scale_factor;
      logic        scale_enabled;
   } tsvd_cfg_type;

   typedef struct packed {
      logic                    err;
      logic                    zero;
      logic                    sign;
      logic signed [EXP_W-1:0] exp;
      logic [52:0]             mant;
   } tsvd_item_type;

   function automatic logic [3:0] type_size(input logic [3:0] pt);
      logic [3:0] s;
      unique case (pt)
         PT_U8, PT_S8:           s = 4'd1;
         PT_U16, PT_S16:         s = 4'd2;
         PT_U24:                 s = 4'd3;
         PT_U32, PT_S32, PT_F32: s = 4'd4;
         default:                s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] lzc32(input logic [31:0] w);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc52(input logic [51:0] w);
      logic [5:0] n;
      n = 6'd52;
      for (int i = 0; i < 52; i++) begin
         if (w[i]) n = 6'(51 - i);
      end
      return n;
   endfunction

endpackage

@@ src/tsvd_if.sv @@
// ---------------------------------------------------------------------------
// tsvd_if
// Request and response channel interfaces (valid/ready).
// ---------------------------------------------------------------------------
interface tsvd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_bytes;
   logic [3:0]  byte_count;
   modport source (output valid, output raw_bytes, output byte_count, input ready);
   modport sink   (input valid, input raw_bytes, input byte_count, output ready);
endinterface

interface tsvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] scaled_value;
   logic        decode_error;
   modport source (output valid, output scaled_value, output decode_error, input ready);
   modport sink   (input valid, input scaled_value, input decode_error, output ready);
endinterface

@@ src/tsvd_front.sv @@
// ---------------------------------------------------------------------------
// tsvd_front
// Accepts a request, assembles bytes, classifies the type and converts the
// value to a normalized sign/exponent/significand record.
// ---------------------------------------------------------------------------
module tsvd_front (
   input  logic                    clock,
   input  logic                    reset,
   tsvd_req_if.sink                req,
   input  tsvd_pkg::tsvd_cfg_type  cfg,
   output tsvd_pkg::tsvd_item_type item,
   output logic                    item_valid,
   input  logic                    item_ready
);
   import tsvd_pkg::*;

   logic          valid_ff, valid_in;
   tsvd_item_type item_ff, item_in;
   logic [31:0]   raw, v, w, mag, shifted;
   logic [3:0]    cnt;
   logic          neg, bad, nonfinite;
   logic [5:0]    lz;
   logic signed [EXP_W-1:0] base;

   always_comb begin
      raw = req.raw_bytes;
      cnt = req.byte_count;
      v   = '0;
      if (cfg.byte_order) begin
         case (cnt)
            4'd1:    v = {24'b0, raw[7:0]};
            4'd2:    v = {16'b0, raw[7:0], raw[15:8]};
            4'd3:    v = {8'b0, raw[7:0], raw[15:8], raw[23:16]};
            4'd4:    v = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            default: v = '0;
         endcase
      end else begin
         case (cnt)
            4'd1:    v = {24'b0, raw[7:0]};
            4'd2:    v = {16'b0, raw[15:0]};
            4'd3:    v = {8'b0, raw[23:0]};
            4'd4:    v = raw;
            default: v = '0;
         endcase
      end

      bad       = (cfg.point_type > PT_F32) || (cnt != type_size(cfg.point_type));
      neg       = 1'b0;
      mag       = v;
      nonfinite = 1'b0;
      base      = 13'sd31;
      unique case (cfg.point_type)
         PT_S8: begin
            neg = v[7];
            mag = neg ? (32'd256 - {24'b0, v[7:0]}) : v;
         end
         PT_S16: begin
            neg = v[15];
            mag = neg ? (32'd65536 - {16'b0, v[15:0]}) : v;
         end
         PT_S32: begin
            neg = v[31];
            mag = neg ? (~v + 32'd1) : v;
         end
         PT_F32: begin
            neg       = v[31];
            nonfinite = (v[30:23] == 8'hFF);
            if (v[30:23] == 8'd0) begin
               mag  = {1'b0, v[22:0], 8'b0};
               base = -13'sd126;
            end else begin
               mag  = {1'b1, v[22:0], 8'b0};
               base = $signed({5'b0, v[30:23]}) - 13'sd127;
            end
         end
         default: begin
            neg = 1'b0;
            mag = v;
         end
      endcase

      w       = mag;
      lz      = lzc32(w);
      shifted = w << lz;

      item_in.err  = bad || nonfinite;
      item_in.zero = (w == 32'd0);
      item_in.sign = neg;
      item_in.exp  = base - $signed({7'b0, lz});
      item_in.mant = {shifted, 21'b0};
   end

   assign req.ready  = !valid_ff || item_ready;
   assign valid_in   = req.ready ? req.valid : valid_ff;
   assign item       = item_ff;
   assign item_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ src/tsvd_fifo.sv @@
// ---------------------------------------------------------------------------
// tsvd_fifo
// Short queue between the classify front and the arithmetic back.
// ---------------------------------------------------------------------------
`include "typed_sensor_value_decoder_macros.svh"

module tsvd_fifo #(
   parameter int DEPTH = tsvd_pkg::TSVD_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tsvd_pkg::tsvd_item_type push_item,
   input  logic                    push_valid,
   output logic                    push_ready,
   output tsvd_pkg::tsvd_item_type pop_item,
   output logic                    pop_valid,
   input  logic                    pop_ready
);
   import tsvd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   tsvd_item_type    mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   `TSVD_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `TSVD_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `TSVD_ASSERT_NEXT(a_ptr_track, clock, reset, push != pop, wr_ptr_ff != $past(wr_ptr_ff) || rd_ptr_ff != $past(rd_ptr_ff))

endmodule

@@ src/tsvd_back.sv @@
// ---------------------------------------------------------------------------
// tsvd_back
// Scale multiply pipeline: operand prep, partial products, sum, normalize,
// denormal shift, round and pack into the output register.
// ---------------------------------------------------------------------------
module tsvd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tsvd_pkg::tsvd_cfg_type  cfg,
   input  tsvd_pkg::tsvd_item_type item,
   input  logic                    item_valid,
   output logic                    item_ready,
   tsvd_rsp_if.source              rsp
);
   import tsvd_pkg::*;

   logic en;
   logic [5:0] v_ff, v_in;

   // stage 0: operands
   logic s0_err_ff, s0_zero_ff, s0_sign_ff;
   logic signed [EXP_W-1:0] s0_exp_ff;
   logic [52:0] s0_ma_ff, s0_mb_ff;
   logic b_err, b_zero, b_sign;
   logic signed [EXP_W-1:0] b_exp;
   logic [52:0] b_mant;
   logic [10:0] es;
   logic [51:0] fs;
   logic [5:0]  slz;

   // stage 1: partial products
   logic s1_err_ff, s1_zero_ff, s1_sign_ff;
   logic signed [EXP_W-1:0] s1_exp_ff;
   logic [63:0] pp_ll_ff;
   logic [52:0] pp_lh_ff, pp_hl_ff;
   logic [41:0] pp_hh_ff;

   // stage 2: product
   logic s2_err_ff, s2_zero_ff, s2_sign_ff;
   logic signed [EXP_W-1:0] s2_exp_ff;
   logic [105:0] s2_p_ff, s2_p_in;

   // stage 3: normalize
   logic s3_err_ff, s3_zero_ff, s3_sign_ff, s3_ovf_ff;
   logic [105:0] s3_m_ff, s3_m_in;
   logic [6:0]   s3_sh_ff, s3_sh_in;
   logic [10:0]  s3_ebm1_ff, s3_ebm1_in;
   logic signed [EXP_W-1:0] ebias, dsh;

   // stage 4: denormal shift
   logic s4_err_ff, s4_zero_ff, s4_sign_ff;
   logic [52:0]  s4_mant_ff;
   logic         s4_guard_ff, s4_sticky_ff;
   logic [10:0]  s4_ebm1_ff;
   logic [105:0] shifted, lost_mask;

   // stage 5: round, pack
   logic        s5_err_ff, s5_err_in;
   logic [63:0] s5_val_ff, s5_val_in;
   logic        round_up;
   logic [53:0] rmant;
   logic [63:0] packed_sum;

   assign en         = !v_ff[5] || rsp.ready;
   assign item_ready = en;
   assign v_in       = {v_ff[4:0], item_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      es     = cfg.scale_factor[62:52];
      fs     = cfg.scale_factor[51:0];
      slz    = lzc52(fs);
      b_err  = 1'b0;
      b_zero = 1'b0;
      b_sign = 1'b0;
      b_exp  = '0;
      b_mant = {1'b1, 52'b0};
      if (cfg.scale_enabled) begin
         b_sign = cfg.scale_factor[63];
         if (es == 11'h7FF) begin
            b_err = 1'b1;
         end else if (es == 11'd0) begin
            b_zero = (fs == 52'd0);
            b_mant = 53'({1'b0, fs} << (slz + 6'd1));
            b_exp  = -13'sd1023 - $signed({7'b0, slz});
         end else begin
            b_mant = {1'b1, fs};
            b_exp  = $signed({2'b0, es}) - 13'sd1023;
         end
      end
   end

   always_comb begin
      s2_p_in = 106'(pp_ll_ff)
              + (106'(54'(pp_lh_ff) + 54'(pp_hl_ff)) << 32)
              + (106'(pp_hh_ff) << 64);
   end

   always_comb begin
      if (s2_p_ff[105]) begin
         s3_m_in = s2_p_ff;
         ebias   = s2_exp_ff + 13'sd1024;
      end else begin
         s3_m_in = s2_p_ff << 1;
         ebias   = s2_exp_ff + 13'sd1023;
      end
      dsh = 13'sd1 - ebias;
      if (ebias <= 13'sd0) begin
         s3_sh_in   = (dsh > 13'sd107) ? 7'd107 : dsh[6:0];
         s3_ebm1_in = '0;
      end else begin
         s3_sh_in   = '0;
         s3_ebm1_in = (ebias >= 13'sd2047) ? 11'd0 : 11'(ebias - 13'sd1);
      end
   end

   always_comb begin
      shifted   = s3_m_ff >> s3_sh_ff;
      lost_mask = (106'(1) << s3_sh_ff) - 106'(1);
   end

   always_comb begin
      round_up   = s4_guard_ff && (s4_sticky_ff || s4_mant_ff[0]);
      rmant      = {1'b0, s4_mant_ff} + 54'(round_up);
      packed_sum = {1'b0, s4_ebm1_ff, 52'b0} + 64'(rmant);
      s5_err_in  = s4_err_ff || (!s4_zero_ff && packed_sum[63:52] >= 12'd2047);
      if (s5_err_in) begin
         s5_val_in = '0;
      end else if (s4_zero_ff) begin
         s5_val_in = {s4_sign_ff, 63'b0};
      end else begin
         s5_val_in = {s4_sign_ff, packed_sum[62:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_err_ff  <= item.err || b_err;
         s0_zero_ff <= item.zero || b_zero;
         s0_sign_ff <= item.sign ^ b_sign;
         s0_exp_ff  <= item.exp + b_exp;
         s0_ma_ff   <= item.mant;
         s0_mb_ff   <= b_mant;

         s1_err_ff  <= s0_err_ff;
         s1_zero_ff <= s0_zero_ff;
         s1_sign_ff <= s0_sign_ff;
         s1_exp_ff  <= s0_exp_ff;
         pp_ll_ff   <= s0_ma_ff[31:0] * s0_mb_ff[31:0];
         pp_lh_ff   <= s0_ma_ff[31:0] * s0_mb_ff[52:32];
         pp_hl_ff   <= s0_ma_ff[52:32] * s0_mb_ff[31:0];
         pp_hh_ff   <= s0_ma_ff[52:32] * s0_mb_ff[52:32];

         s2_err_ff  <= s1_err_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_p_ff    <= s2_p_in;

         s3_err_ff  <= s2_err_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_ovf_ff  <= !s2_zero_ff && (ebias >= 13'sd2047);
         s3_m_ff    <= s3_m_in;
         s3_sh_ff   <= s3_sh_in;
         s3_ebm1_ff <= s3_ebm1_in;

         s4_err_ff    <= s3_err_ff || s3_ovf_ff;
         s4_zero_ff   <= s3_zero_ff;
         s4_sign_ff   <= s3_sign_ff;
         s4_mant_ff   <= shifted[105:53];
         s4_guard_ff  <= shifted[52];
         s4_sticky_ff <= (|shifted[51:0]) || (|(s3_m_ff & lost_mask));
         s4_ebm1_ff   <= s3_ebm1_ff;

         s5_err_ff <= s5_err_in;
         s5_val_ff <= s5_val_in;
      end
   end

   assign rsp.valid        = v_ff[5];
   assign rsp.scaled_value = s5_val_ff;
   assign rsp.decode_error = s5_err_ff;

endmodule

@@ src/typed_sensor_value_decoder.sv @@
// Path from request acceptance to response valid: front register loads at acceptance,
// queue write, six-stage multiply/round pipeline.
// Throughput: one transaction per cycle; the back pipeline advances whenever
// the response register is empty or taken.
// Reset (synchronous, active high) empties all stages and the queue and sets
// point_type 0, little-endian, scale 1.0, scaling off.
// ---------------------------------------------------------------------------
// typed_sensor_value_decoder
// Decodes raw register bytes into a typed value, converts to double and
// optionally multiplies by a configured double scale.
// ---------------------------------------------------------------------------
module typed_sensor_value_decoder #(
   parameter int QUEUE_DEPTH = tsvd_pkg::TSVD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tsvd_req_if.sink    req,
   tsvd_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import tsvd_pkg::*;

   tsvd_cfg_type  cfg_ff, cfg_in;
   tsvd_item_type front_item, queue_item;
   logic          front_valid, front_ready, queue_valid, queue_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POINT_TYPE:    cfg_in.point_type    = csr_write_data[3:0];
            CSR_BYTE_ORDER:    cfg_in.byte_order    = csr_write_data[0];
            CSR_SCALE_FACTOR:  cfg_in.scale_factor  = csr_write_data;
            CSR_SCALE_ENABLED: cfg_in.scale_enabled = csr_write_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_type    <= PT_U8;
         cfg_ff.byte_order    <= 1'b0;
         cfg_ff.scale_factor  <= SCALE_RESET;
         cfg_ff.scale_enabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   tsvd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_item   (queue_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready)
   );

   tsvd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (queue_item),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .rsp        (rsp)
   );

endmodule
